[hw/rtl/terminal_line_filter_defines.svh]
// assertion macros shared by the terminal line filter checkers
// no dependencies; included by files that hold concurrent assertions
`ifndef TERMINAL_LINE_FILTER_DEFINES_SVH
`define TERMINAL_LINE_FILTER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define TLF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("terminal_line_filter check failed");

// next-cycle implication, disabled while reset is held
`define TLF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("terminal_line_filter check failed");

`endif

[hw/rtl/tlf_pkg.sv]
// shared types, byte codes and helpers of the terminal line filter
// no dependencies
`timescale 1ns / 1ps

package tlf_pkg;

  // configuration register indexes
  localparam logic CFG_SHOW_ESCAPES = 1'b0;
  localparam logic CFG_MAX_COLUMNS  = 1'b1;

  // reset values of the configuration registers
  localparam logic       SHOW_ESCAPES_RST = 1'b1;
  localparam logic [7:0] MAX_COLUMNS_RST  = 8'd80;

  // byte codes with a meaning of their own
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;

  // step of the item being worked on
  typedef enum logic [1:0] {
    PH_START,
    PH_TAB,
    PH_END
  } phase_t;

  // bytes that keep an escape run open
  function automatic logic is_escape_char(input logic [7:0] c);
    return (c == CH_LBRK) || (c == CH_SEMI) || (c == CH_COMMA) ||
           ((c >= CH_ZERO) && (c <= CH_NINE));
  endfunction

  // bytes that are stored and take a column
  function automatic logic is_printable(input logic [7:0] c);
    return ((c >= CH_SPACE) && (c <= CH_TILDE)) || (c >= CH_HIGH);
  endfunction

endpackage

[hw/rtl/terminal_line_filter.sv]
// terminal line filter top level: byte stream in, characters and line end markers out
// depends on tlf_pkg
`timescale 1ns / 1ps

// Takes one raw text byte per transaction and returns the stored characters and
// end-of-line markers it causes. Most bytes need no extra step, so a byte can be
// taken in every cycle unless a stalled result holds it. A tab emits one space per
// column it spans (up to 8), and a byte that stores a character and also ends the
// line emits the two one after the other, because the single result register
// carries one result per cycle. A result waiting in the output register does not
// block a byte that causes no result. show_escapes (index 0) and max_columns (index 1)
// are written through the cfg port, which is always ready; write them only while no transaction is in flight.
module terminal_line_filter #(
  parameter int STORE_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_char_valid,
  output logic        out_line_done,
  output logic [15:0] out_line_bytes,
  output logic        out_bell,
  output logic        out_last,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import tlf_pkg::*;

  localparam int CNT_W = $clog2(STORE_LIMIT + 1);
  localparam logic [CNT_W-1:0] STORE_FULL = CNT_W'(STORE_LIMIT);

  // configuration registers
  logic       show_esc_r;
  logic [7:0] max_col_r;

  // held item
  logic       item_valid_r;
  logic [7:0] item_byte_r;
  logic       item_eoi_r;
  phase_t     phase_r, phase_nxt;

  // line state
  logic [7:0]       column_r;
  logic [CNT_W-1:0] stored_r;
  logic             esc_r;
  logic             bell_r;
  logic [15:0]      bcount_r;

  // result register
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_char_valid_r;
  logic        out_line_done_r;
  logic [15:0] out_line_bytes_r;
  logic        out_bell_r;
  logic        out_last_r;

  // step decode
  logic [7:0]       col_n;
  logic [CNT_W-1:0] cnt_n;
  logic             esc_n;
  logic             bell_n;
  logic [15:0]      bc_n;
  logic             emit_chr;
  logic [7:0]       chr;
  logic             forced_end;
  logic             limit_end;
  logic             tab_step;
  logic             tab_more;
  logic             room;
  logic             emit_end;
  logic             emit;
  logic             finish;
  logic             out_free;
  logic             go;
  logic             step;
  logic             in_accept;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_esc_r <= SHOW_ESCAPES_RST;
      max_col_r  <= MAX_COLUMNS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHOW_ESCAPES: show_esc_r <= cfg_data[0];
        CFG_MAX_COLUMNS:  max_col_r  <= cfg_data;
        default:          show_esc_r <= show_esc_r;
      endcase
    end
  end

  // what one step of the held item does
  always_comb begin
    col_n      = column_r;
    esc_n      = esc_r;
    bell_n     = bell_r;
    bc_n       = bcount_r;
    emit_chr   = 1'b0;
    chr        = CH_SPACE;
    forced_end = 1'b0;
    tab_step   = 1'b0;
    tab_more   = 1'b0;
    limit_end  = 1'b0;
    room       = (stored_r < STORE_FULL);
    unique case (phase_r)
      PH_START: begin
        if (item_eoi_r) begin
          forced_end = 1'b1;
        end else begin
          bc_n = (bcount_r == BYTE_COUNT_MAX) ? bcount_r : bcount_r + 16'd1;
          if (item_byte_r == CH_LF) begin
            forced_end = 1'b1;
          end else if (item_byte_r == CH_TAB) begin
            tab_step = 1'b1;
          end else if (item_byte_r == CH_BEL) begin
            bell_n = 1'b1;
          end else if (item_byte_r == CH_ESC) begin
            emit_chr = show_esc_r && room;
            chr      = item_byte_r;
            esc_n    = 1'b1;
          end else if (esc_r) begin
            emit_chr = show_esc_r && room;
            chr      = item_byte_r;
            if (!is_escape_char(item_byte_r)) begin
              esc_n = 1'b0;
            end
          end else if (is_printable(item_byte_r)) begin
            emit_chr = room;
            chr      = item_byte_r;
            col_n    = column_r + 8'd1;
          end
        end
      end
      PH_TAB: begin
        tab_step = 1'b1;
      end
      PH_END: begin
        forced_end = 1'b1;
      end
      default: begin
        forced_end = 1'b1;
      end
    endcase
    // one space of a tab run
    if (tab_step) begin
      emit_chr = room;
      chr      = CH_SPACE;
      col_n    = column_r + 8'd1;
      tab_more = (col_n[2:0] != 3'd0) && (col_n < max_col_r);
    end
    cnt_n = stored_r + CNT_W'(emit_chr);
    // limits are checked once the byte is fully handled
    if (!forced_end && !tab_more) begin
      limit_end = (col_n >= max_col_r) || (cnt_n >= STORE_FULL);
    end
  end

  // step control and handshake
  assign emit_end  = !emit_chr && (forced_end || limit_end);
  assign emit      = emit_chr || emit_end;
  assign finish    = !tab_more && !(emit_chr && limit_end);
  assign out_free  = !out_valid_r || !out_stall;
  assign go        = !emit || out_free;
  assign step      = item_valid_r && go;
  assign in_stall  = item_valid_r && !(go && finish);
  assign in_accept = in_valid && !in_stall;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      priority if (tab_more) begin
        phase_nxt = PH_TAB;
      end else if (emit_chr && limit_end) begin
        phase_nxt = PH_END;
      end else begin
        phase_nxt = PH_START;
      end
    end
  end

  // held item and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      phase_r      <= PH_START;
    end else begin
      phase_r <= phase_nxt;
      if (in_accept) begin
        item_valid_r <= 1'b1;
      end else if (step && finish) begin
        item_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_byte_r <= in_data_byte;
      item_eoi_r  <= in_end_of_input;
    end
  end

  // line state, cleared by every end marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      stored_r <= '0;
      esc_r    <= 1'b0;
      bell_r   <= 1'b0;
      bcount_r <= '0;
    end else if (step) begin
      if (emit_end) begin
        column_r <= '0;
        stored_r <= '0;
        esc_r    <= 1'b0;
        bell_r   <= 1'b0;
        bcount_r <= '0;
      end else begin
        column_r <= col_n;
        stored_r <= cnt_n;
        esc_r    <= esc_n;
        bell_r   <= bell_n;
        bcount_r <= bc_n;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_char_r       <= emit_chr ? chr : 8'd0;
      out_char_valid_r <= emit_chr;
      out_line_done_r  <= emit_end;
      out_line_bytes_r <= emit_end ? bc_n : 16'd0;
      out_bell_r       <= emit_end && bell_n;
      out_last_r       <= finish;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_char_valid = out_char_valid_r;
  assign out_line_done  = out_line_done_r;
  assign out_line_bytes = out_line_bytes_r;
  assign out_bell       = out_bell_r;
  assign out_last       = out_last_r;

endmodule

[hw/rtl/tlf_checker.sv]
// port-level checks of the terminal line filter, bound to the top level
// depends on terminal_line_filter_defines.svh and terminal_line_filter
`timescale 1ns / 1ps
`include "terminal_line_filter_defines.svh"

module tlf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_char,
  input logic        out_char_valid,
  input logic        out_line_done,
  input logic [15:0] out_line_bytes,
  input logic        out_bell,
  input logic        out_last
);

  // a stalled result transaction holds
  `TLF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_char) && $stable(out_line_bytes) && $stable(out_last))

  // every result is either a character or an end marker
  `TLF_ASSERT_IMP(a_one_kind, clk, rst_n, out_valid, out_char_valid ^ out_line_done)

  // an end marker always closes the work of its byte
  `TLF_ASSERT_IMP(a_end_last, clk, rst_n, out_valid && out_line_done, out_last && (out_char == 8'd0))

  // character results carry no line summary
  `TLF_ASSERT_IMP(a_char_clean, clk, rst_n, out_valid && out_char_valid, (out_line_bytes == 16'd0) && !out_bell)

endmodule

bind terminal_line_filter tlf_checker u_tlf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char       (out_char),
  .out_char_valid (out_char_valid),
  .out_line_done  (out_line_done),
  .out_line_bytes (out_line_bytes),
  .out_bell       (out_bell),
  .out_last       (out_last)
);

[sim/tb_terminal_line_filter.sv]
`timescale 1ns / 1ps
// self-checking testbench of the terminal line filter: bytes in, characters and line markers out
// depends on tlf_pkg and terminal_line_filter; a line tracker class predicts every result

module tb_terminal_line_filter;
  import tlf_pkg::*;

  localparam int STORE_LIMIT    = 256;
  localparam int RUN_LIMIT      = 800000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 300;

  // one result transaction, in port order
  typedef struct packed {
    logic [7:0]  ch;
    logic        char_valid;
    logic        line_done;
    logic [15:0] line_bytes;
    logic        bell;
    logic        last;
  } line_result_t;

  // tracks the line being built and queues the results each byte causes
  class line_tracker;
    bit           show_esc = SHOW_ESCAPES_RST;
    bit [7:0]     max_cols = MAX_COLUMNS_RST;
    bit [7:0]     column;
    bit [8:0]     stored;
    bit           in_esc;
    bit           bell_pend;
    bit [15:0]    byte_cnt;
    line_result_t pending_results[$];
    int unsigned  mismatch_count;

    // end marker, then a fresh line
    function void close_line();
      pending_results.push_back(line_result_t'({8'h00, 1'b0, 1'b1, byte_cnt, bell_pend, 1'b0}));
      column    = '0;
      stored    = '0;
      in_esc    = 1'b0;
      bell_pend = 1'b0;
      byte_cnt  = '0;
    endfunction

    // characters past the store limit are dropped
    function void store_char(bit [7:0] ch);
      if (stored < STORE_LIMIT) begin
        pending_results.push_back(line_result_t'({ch, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}));
        stored++;
      end
    endfunction

    // note an accepted input transaction
    function void take_byte(bit [7:0] c, bit eoi);
      int unsigned first;
      first = pending_results.size();
      if (eoi) begin
        close_line();
      end else begin
        if (byte_cnt != BYTE_COUNT_MAX) byte_cnt++;
        if (c == CH_LF) begin
          close_line();
        end else begin
          if (c == CH_TAB) begin
            // at least one space, stop on a tab stop or the column limit
            do begin
              store_char(CH_SPACE);
              column++;
            end while (column[2:0] != 3'd0 && column < max_cols);
          end else if (c == CH_BEL) begin
            bell_pend = 1'b1;
          end else if (c == CH_ESC) begin
            if (show_esc) store_char(c);
            in_esc = 1'b1;
          end else if (in_esc) begin
            // the byte closing a run is passed on only while escapes are shown, without a column
            if (show_esc) store_char(c);
            if (!(c == CH_LBRK || c == CH_SEMI || c == CH_COMMA ||
                  (c >= CH_ZERO && c <= CH_NINE)))
              in_esc = 1'b0;
          end else if ((c >= CH_SPACE && c <= CH_TILDE) || c >= CH_HIGH) begin
            store_char(c);
            column++;
          end
          if (column >= max_cols || stored >= STORE_LIMIT) close_line();
        end
      end
      if (pending_results.size() > first)
        pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string port_name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, port_name, want, got);
        mismatch_count++;
      end
    endfunction

    // check a result transaction against the oldest expectation
    function void check_result(line_result_t got);
      line_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: expected no result, got char %0h valid %b done %b bytes %0d bell %b last %b",
                 $time, got.ch, got.char_valid, got.line_done, got.line_bytes, got.bell,
                 got.last);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("out_char", 16'(want.ch), 16'(got.ch));
      compare_field("out_char_valid", 16'(want.char_valid), 16'(got.char_valid));
      compare_field("out_line_done", 16'(want.line_done), 16'(got.line_done));
      compare_field("out_line_bytes", want.line_bytes, got.line_bytes);
      compare_field("out_bell", 16'(want.bell), 16'(got.bell));
      compare_field("out_last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        out_char_valid;
  logic        out_line_done;
  logic [15:0] out_line_bytes;
  logic        out_bell;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_SHOW_ESCAPES;
  logic [7:0]  cfg_data = 8'h00;

  line_tracker tracker;
  bit          sender_idle = 1'b1;
  bit          hold_out_req = 1'b0;
  int unsigned sent_items = 0;
  int unsigned cycle_count = 0;

  terminal_line_filter #(
    .STORE_LIMIT(STORE_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_end_of_input(in_end_of_input),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .out_char_valid(out_char_valid),
    .out_line_done(out_line_done),
    .out_line_bytes(out_line_bytes),
    .out_bell(out_bell),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_result({out_char, out_char_valid, out_line_done, out_line_bytes,
                            out_bell, out_last});
  end

  // receiver stalls: free stretches, short stalls, long stalls, one requested hold-off
  initial begin
    int unsigned pick;
    int unsigned span;
    forever begin
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          out_stall <= 1'b0;
          span = $urandom_range(10, 60);
        end else if (pick < 8) begin
          out_stall <= pick[0];
          span = $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(10, 40);
        end
        for (int i = 0; i < span && !hold_out_req; i++) @(posedge clk);
      end
    end
  end

  // offer one input transaction after an optional gap, return at its acceptance edge
  task automatic send_item(input logic [7:0] data, input logic eoi);
    int unsigned gap;
    int unsigned pick;
    gap = 0;
    if (sender_idle) begin
      pick = $urandom_range(0, 9);
      if (pick >= 9) gap = $urandom_range(8, 30);
      else if (pick >= 6) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_byte(data, eoi);
    sent_items++;
  endtask

  // stop offering, wait for every expected result and let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write both registers while idle
  task automatic apply_config(input bit show, input bit [7:0] cols);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SHOW_ESCAPES;
    cfg_data <= {7'd0, show};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_index <= CFG_MAX_COLUMNS;
    cfg_data <= cols;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    tracker.show_esc = show;
    tracker.max_cols = cols;
  endtask

  // mostly well-formed text lines, tab runs and escape sequences; some noise
  task automatic send_random_text(input int unsigned budget);
    int unsigned stop_at;
    int unsigned kind;
    logic [7:0]  ch;
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 11);
      if (kind < 6) begin
        // text line with tabs, bells and escape sequences
        repeat ($urandom_range(0, 20)) begin
          case ($urandom_range(0, 19))
            0: send_item(CH_TAB, 1'b0);
            1: send_item(CH_BEL, 1'b0);
            2: begin
              send_item(CH_ESC, 1'b0);
              send_item(CH_LBRK, 1'b0);
              repeat ($urandom_range(1, 3))
                send_item(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
              if ($urandom_range(0, 1)) begin
                send_item($urandom_range(0, 1) ? CH_SEMI : CH_COMMA, 1'b0);
                repeat ($urandom_range(1, 2))
                  send_item(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
              end
              send_item(8'($urandom_range(8'h40, CH_TILDE)), 1'b0);
            end
            3: send_item(8'($urandom_range(0, 255)), 1'b0);
            default: begin
              ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(CH_HIGH, 8'hFF))
                                               : 8'($urandom_range(CH_SPACE, CH_TILDE));
              send_item(ch, 1'b0);
            end
          endcase
        end
        case ($urandom_range(0, 9))
          0: send_item(8'($urandom_range(0, 255)), 1'b1);
          1: ;
          default: send_item(CH_LF, 1'b0);
        endcase
      end else if (kind < 8) begin
        // tab run long enough to reach the column limit
        repeat ($urandom_range(1, 34)) begin
          if ($urandom_range(0, 3) == 0)
            send_item(8'($urandom_range(CH_SPACE, CH_TILDE)), 1'b0);
          send_item(CH_TAB, 1'b0);
        end
      end else if (kind < 10) begin
        // raw noise
        repeat ($urandom_range(1, 8))
          send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (kind == 10) begin
        // broken escape sequence
        send_item(CH_ESC, 1'b0);
        repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    sender_idle = 1'b1;
  endtask

  // stimulus
  initial begin
    logic [8:0] opening_seq[$];
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty end, field extremes, dropped bytes, bell, tab, escape runs
    opening_seq = '{
      {1'b1, 8'h00}, {1'b0, 8'h41}, {1'b0, CH_SPACE}, {1'b0, CH_TILDE}, {1'b0, CH_HIGH},
      {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'h1F}, {1'b0, 8'h7F}, {1'b0, CH_BEL},
      {1'b0, CH_TAB}, {1'b0, CH_ESC}, {1'b0, CH_LBRK}, {1'b0, 8'h33}, {1'b0, 8'h31},
      {1'b0, CH_SEMI}, {1'b0, CH_COMMA}, {1'b0, 8'h6D}, {1'b0, CH_ESC}, {1'b0, CH_LF},
      {1'b0, CH_ESC}, {1'b0, CH_TAB}, {1'b0, CH_ESC}, {1'b0, CH_NINE}, {1'b0, 8'h78},
      {1'b1, 8'hFF}
    };
    foreach (opening_seq[i]) send_item(opening_seq[i][7:0], opening_seq[i][8]);

    // default settings, with a long receiver hold-off to back up the input
    hold_out_req = 1'b1;
    send_random_text(45);

    // narrow lines, escapes stripped: newline right after a cut
    apply_config(1'b0, 8'd8);
    send_item(8'h00, 1'b1);
    repeat (8) send_item(8'h61, 1'b0);
    send_item(CH_LF, 1'b0);
    send_random_text(40);

    // widest lines: fill the store with tabs and an escape run
    apply_config(1'b1, 8'd255);
    send_item(8'h00, 1'b1);
    repeat (31) send_item(CH_TAB, 1'b0);
    send_item(CH_ESC, 1'b0);
    send_item(CH_LBRK, 1'b0);
    repeat (9) send_item(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
    send_item(CH_LF, 1'b0);
    send_random_text(45);

    // zero columns: every byte ends its line
    apply_config(1'b0, 8'd0);
    send_random_text(30);

    // limit below one tab stop
    apply_config(1'b1, 8'd5);
    send_random_text(30);

    // random settings
    apply_config(1'($urandom_range(0, 1)), 8'($urandom_range(8, 255)));
    send_random_text(45);

    wait_idle();
    if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
